// File: rtl/scf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the cross-kernel sharpening filter.
package scf_pkg;

    localparam int FW_BITS       = 11;
    localparam int FH_BITS       = 13;
    localparam int ROW_BITS      = 12;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 13;
    localparam int MAX_HEIGHT    = 4096;
    localparam int FW_RESET      = 640;
    localparam int FH_RESET      = 480;
    localparam int NUM_SLOTS     = 4;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic r_nz;
        logic r_one;
        logic c_nz;
        logic c_ge2;
        logic end_col;
        logic last_row;
    } win_flags_t;

    typedef struct packed {
        logic                 load;
        logic [NUM_SLOTS-1:0] mask;
    } bank_load_t;

endpackage

// File: rtl/scf_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
module scf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/scf_kernel.sv
`timescale 1ns / 1ps
// Cross-kernel window: edge replication and the four candidate sharpened pixels.
module scf_kernel import scf_pkg::*; #(
    parameter int CHANNEL_BITS = 8
) (
    input  win_flags_t                                flags,
    input  logic [3*CHANNEL_BITS-1:0]                 x,
    input  logic [3*CHANNEL_BITS-1:0]                 p0,
    input  logic [3*CHANNEL_BITS-1:0]                 oc,
    input  logic [3*CHANNEL_BITS-1:0]                 o1,
    input  logic [3*CHANNEL_BITS-1:0]                 p1,
    input  logic [3*CHANNEL_BITS-1:0]                 p2,
    input  logic [3*CHANNEL_BITS-1:0]                 c1,
    input  logic [3*CHANNEL_BITS-1:0]                 c2,
    output logic [NUM_SLOTS-1:0][3*CHANNEL_BITS-1:0] res,
    output logic [NUM_SLOTS-1:0]                      mask
);

    localparam int CB = CHANNEL_BITS;
    localparam int PW = 3 * CHANNEL_BITS;

    function automatic logic [CB-1:0] sharp_ch(
        input logic [CB-1:0] ce,
        input logic [CB-1:0] up,
        input logic [CB-1:0] dn,
        input logic [CB-1:0] lf,
        input logic [CB-1:0] rt
    );
        logic [CB+3:0] five;
        logic [CB+3:0] sum;
        logic [CB+3:0] diff;
        five = {2'b00, ce, 2'b00} + {4'b0000, ce};
        sum  = {4'b0000, up} + {4'b0000, dn} + {4'b0000, lf} + {4'b0000, rt};
        diff = five - sum;
        if (diff[CB+3])
        begin
            sharp_ch = '0;
        end
        else if (|diff[CB+2:CB])
        begin
            sharp_ch = '1;
        end
        else
        begin
            sharp_ch = diff[CB-1:0];
        end
    endfunction

    function automatic logic [PW-1:0] sharp_pix(
        input logic [PW-1:0] ce,
        input logic [PW-1:0] up,
        input logic [PW-1:0] dn,
        input logic [PW-1:0] lf,
        input logic [PW-1:0] rt
    );
        logic [PW-1:0] pix;
        pix = '0;
        for (int i = 0; i < 3; i++)
        begin
            pix[i*CB +: CB] = sharp_ch(ce[i*CB +: CB], up[i*CB +: CB], dn[i*CB +: CB],
                                       lf[i*CB +: CB], rt[i*CB +: CB]);
        end
        sharp_pix = pix;
    endfunction

    always_comb
    begin
        res[0] = sharp_pix(p1, flags.r_one ? p1 : o1, c1, flags.c_ge2 ? p2 : p1, p0);
        res[1] = sharp_pix(p0, flags.r_one ? p0 : oc, x, flags.c_nz ? p1 : p0, p0);
        res[2] = sharp_pix(c1, flags.r_nz ? p1 : c1, c1, flags.c_ge2 ? c2 : c1, x);
        res[3] = sharp_pix(x, flags.r_nz ? p0 : x, x, flags.c_nz ? c1 : x, x);
        mask[0] = flags.r_nz && flags.c_nz;
        mask[1] = flags.r_nz && flags.end_col;
        mask[2] = flags.last_row && flags.c_nz;
        mask[3] = flags.last_row && flags.end_col;
    end

endmodule

// File: rtl/scf_result_bank.sv
`timescale 1ns / 1ps
// Result bank: holds the up to four results of one pixel and drains them in order.
module scf_result_bank import scf_pkg::*; #(
    parameter int CHANNEL_BITS = 8,
    parameter int COL_W        = 10
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  bank_load_t                                ld,
    input  logic [NUM_SLOTS-1:0][3*CHANNEL_BITS-1:0] ld_data,
    input  logic [ROW_BITS-1:0]                       ld_row,
    input  logic [COL_W-1:0]                          ld_col,
    output logic                                      free,
    output logic                                      result_valid,
    input  logic                                      result_stall,
    output logic [3*CHANNEL_BITS-1:0]                 pix,
    output logic [ROW_BITS-1:0]                       row,
    output logic [COL_W-1:0]                          col,
    output logic                                      run_last,
    output logic                                      frame_last
);

    logic [NUM_SLOTS-1:0]                      mask_reg;
    logic [NUM_SLOTS-1:0]                      mask_next;
    logic [NUM_SLOTS-1:0][3*CHANNEL_BITS-1:0] data_reg;
    logic [ROW_BITS-1:0]                       row_reg;
    logic [COL_W-1:0]                          col_reg;
    logic [1:0]                                sel;
    logic                                      pop;
    logic                                      single;

    always_comb
    begin
        if (mask_reg[0])
        begin
            sel = 2'd0;
        end
        else if (mask_reg[1])
        begin
            sel = 2'd1;
        end
        else if (mask_reg[2])
        begin
            sel = 2'd2;
        end
        else
        begin
            sel = 2'd3;
        end
    end

    assign single       = (mask_reg & (mask_reg - 1'b1)) == '0;
    assign result_valid = |mask_reg;
    assign pop          = result_valid && !result_stall;
    assign free         = !result_valid || (pop && single);

    always_comb
    begin
        mask_next = mask_reg;
        if (ld.load)
        begin
            mask_next = ld.mask;
        end
        else if (pop)
        begin
            mask_next = mask_reg & (mask_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.load)
        begin
            data_reg <= ld_data;
            row_reg  <= ld_row;
            col_reg  <= ld_col;
        end
    end

    assign pix        = data_reg[sel];
    assign row        = sel[1] ? row_reg : row_reg - 1'b1;
    assign col        = sel[0] ? col_reg : col_reg - 1'b1;
    assign run_last   = single;
    assign frame_last = (sel == 2'd3);

endmodule

// File: rtl/sharpen_cross_kernel_filter.sv
`timescale 1ns / 1ps
// Top level of the cross-kernel sharpening filter: line buffers, window and control.
// The results caused by an accepted pixel pass the window registers, then the result bank.
// Throughput: one pixel per cycle while each pixel gives at most one result and
//   result_stall is low; at a row end or on the last row a pixel gives up to four,
//   drained one per cycle through the result bank, and pixel_stall holds the input for the extra cycles.
// Reset: counters, window registers and handshake state clear, frame size 640 x 480;
//   the line buffers are not cleared and need no clearing pass.
module sharpen_cross_kernel_filter import scf_pkg::*; #(
    parameter int MAX_WIDTH    = 1024,
    parameter int CHANNEL_BITS = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                         pixel_valid,
    output logic                         pixel_stall,
    input  logic [CHANNEL_BITS-1:0]      red_in,
    input  logic [CHANNEL_BITS-1:0]      green_in,
    input  logic [CHANNEL_BITS-1:0]      blue_in,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [CHANNEL_BITS-1:0]      red_out,
    output logic [CHANNEL_BITS-1:0]      green_out,
    output logic [CHANNEL_BITS-1:0]      blue_out,
    output logic [ROW_BITS-1:0]          out_row,
    output logic [$clog2(MAX_WIDTH)-1:0] out_col,
    output logic                         run_last,
    output logic                         frame_last
);

    localparam int CB    = CHANNEL_BITS;
    localparam int PW    = 3 * CHANNEL_BITS;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WB    = (COL_W + 1 > FW_BITS) ? COL_W + 1 : FW_BITS;

    logic [FW_BITS-1:0]  frame_width_reg;
    logic [FH_BITS-1:0]  frame_height_reg;
    logic [COL_W-1:0]    col_cnt_reg;
    logic [COL_W-1:0]    col_cnt_next;
    logic [ROW_BITS-1:0] row_cnt_reg;
    logic [ROW_BITS-1:0] row_cnt_next;

    logic [WB-1:0]       fw_ext;
    logic [WB-1:0]       w_eff;
    logic [FH_BITS-1:0]  h_eff;
    logic [COL_W-1:0]    last_col;
    logic [ROW_BITS-1:0] last_row_idx;
    logic [COL_W-1:0]    c_acc;
    logic [COL_W-1:0]    c_acc_m1;
    logic [ROW_BITS-1:0] r_acc;
    win_flags_t          flags_acc;
    logic                accept;
    logic                advance;
    logic                bank_free;
    logic [PW-1:0]       x_in;

    logic                a_valid_reg;
    logic [PW-1:0]       a_pix_reg;
    logic [COL_W-1:0]    a_col_reg;
    logic [ROW_BITS-1:0] a_row_reg;
    win_flags_t          a_flags_reg;

    logic [PW-1:0]       p1_reg;
    logic [PW-1:0]       p2_reg;
    logic [PW-1:0]       c1_reg;
    logic [PW-1:0]       c2_reg;

    logic [PW-1:0]       prev_rd;
    logic [PW-1:0]       older_a_rd;
    logic [PW-1:0]       older_b_rd;
    logic [PW-1:0]       oc;
    logic [PW-1:0]       o1;

    logic                older_prim_we;
    logic                older_we;
    logic [COL_W-1:0]    older_waddr;
    logic [PW-1:0]       older_wdata;
    logic                sec_pend_reg;
    logic [COL_W-1:0]    sec_addr_reg;
    logic [PW-1:0]       sec_data_reg;

    logic                byp_a_hit_reg;
    logic                byp_b_hit_reg;
    logic [PW-1:0]       byp_a_data_reg;
    logic [PW-1:0]       byp_b_data_reg;

    logic [NUM_SLOTS-1:0][PW-1:0] kern_res;
    logic [NUM_SLOTS-1:0]         kern_mask;
    bank_load_t                   bank_ld;
    logic [PW-1:0]                out_pix;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FW_BITS'(FW_RESET);
            frame_height_reg <= FH_BITS'(FH_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FW_BITS-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FH_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // frame bounds and position of the incoming pixel
    always_comb
    begin
        fw_ext = WB'(frame_width_reg);
        if (fw_ext == '0)
        begin
            w_eff = WB'(1);
        end
        else if (fw_ext > WB'(MAX_WIDTH))
        begin
            w_eff = WB'(MAX_WIDTH);
        end
        else
        begin
            w_eff = fw_ext;
        end
        if (frame_height_reg == '0)
        begin
            h_eff = FH_BITS'(1);
        end
        else if (frame_height_reg > FH_BITS'(MAX_HEIGHT))
        begin
            h_eff = FH_BITS'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = frame_height_reg;
        end
        last_col     = COL_W'(w_eff - WB'(1));
        last_row_idx = ROW_BITS'(h_eff - FH_BITS'(1));
        c_acc        = (col_cnt_reg > last_col) ? last_col : col_cnt_reg;
        r_acc        = (row_cnt_reg > last_row_idx) ? last_row_idx : row_cnt_reg;
        c_acc_m1     = c_acc - 1'b1;
        flags_acc.r_nz     = (r_acc != '0);
        flags_acc.r_one    = (r_acc == ROW_BITS'(1));
        flags_acc.c_nz     = (c_acc != '0);
        flags_acc.c_ge2    = (c_acc > COL_W'(1));
        flags_acc.end_col  = (c_acc == last_col);
        flags_acc.last_row = (r_acc == last_row_idx);
    end

    assign x_in        = {red_in, green_in, blue_in};
    assign advance     = a_valid_reg && bank_free;
    assign pixel_stall = a_valid_reg && !bank_free;
    assign accept      = pixel_valid && !pixel_stall;

    always_comb
    begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (accept)
        begin
            if (flags_acc.end_col)
            begin
                col_cnt_next = '0;
                row_cnt_next = flags_acc.last_row ? '0 : r_acc + 1'b1;
            end
            else
            begin
                col_cnt_next = c_acc + 1'b1;
                row_cnt_next = r_acc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
            if (accept)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_pix_reg   <= x_in;
            a_col_reg   <= c_acc;
            a_row_reg   <= r_acc;
            a_flags_reg <= flags_acc;
        end
    end

    // line buffers
    scf_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_prev_row (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (c_acc),
        .wr_data (x_in),
        .rd_en   (accept),
        .rd_addr (c_acc),
        .rd_data (prev_rd)
    );

    // older row: one copy per read column, both written alike
    assign older_prim_we = advance && (a_flags_reg.c_nz || a_flags_reg.end_col);
    assign older_we      = older_prim_we || sec_pend_reg;

    always_comb
    begin
        if (sec_pend_reg)
        begin
            older_waddr = sec_addr_reg;
            older_wdata = sec_data_reg;
        end
        else if (a_flags_reg.c_nz)
        begin
            older_waddr = a_col_reg - 1'b1;
            older_wdata = p1_reg;
        end
        else
        begin
            older_waddr = a_col_reg;
            older_wdata = prev_rd;
        end
    end

    scf_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_older_cur (
        .clk     (clk),
        .wr_en   (older_we),
        .wr_addr (older_waddr),
        .wr_data (older_wdata),
        .rd_en   (accept),
        .rd_addr (c_acc),
        .rd_data (older_a_rd)
    );

    scf_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_older_left (
        .clk     (clk),
        .wr_en   (older_we),
        .wr_addr (older_waddr),
        .wr_data (older_wdata),
        .rd_en   (accept),
        .rd_addr (c_acc_m1),
        .rd_data (older_b_rd)
    );

    // forward a write that lands on the read edge
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_a_hit_reg <= 1'b0;
            byp_b_hit_reg <= 1'b0;
            sec_pend_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                byp_a_hit_reg <= older_we && (older_waddr == c_acc);
                byp_b_hit_reg <= older_we && (older_waddr == c_acc_m1);
            end
            sec_pend_reg <= advance && a_flags_reg.c_nz && a_flags_reg.end_col;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byp_a_data_reg <= older_wdata;
            byp_b_data_reg <= older_wdata;
        end
        if (advance)
        begin
            sec_addr_reg <= a_col_reg;
            sec_data_reg <= prev_rd;
        end
    end

    assign oc = byp_a_hit_reg ? byp_a_data_reg : older_a_rd;
    assign o1 = !a_flags_reg.c_nz ? oc : (byp_b_hit_reg ? byp_b_data_reg : older_b_rd);

    // window history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg <= '0;
            p2_reg <= '0;
            c1_reg <= '0;
            c2_reg <= '0;
        end
        else if (advance)
        begin
            p2_reg <= p1_reg;
            p1_reg <= prev_rd;
            c2_reg <= c1_reg;
            c1_reg <= a_pix_reg;
        end
    end

    scf_kernel #(
        .CHANNEL_BITS (CB)
    ) u_kernel (
        .flags (a_flags_reg),
        .x     (a_pix_reg),
        .p0    (prev_rd),
        .oc    (oc),
        .o1    (o1),
        .p1    (p1_reg),
        .p2    (p2_reg),
        .c1    (c1_reg),
        .c2    (c2_reg),
        .res   (kern_res),
        .mask  (kern_mask)
    );

    assign bank_ld.load = advance;
    assign bank_ld.mask = kern_mask;

    scf_result_bank #(
        .CHANNEL_BITS (CB),
        .COL_W        (COL_W)
    ) u_bank (
        .clk          (clk),
        .rst_n        (rst_n),
        .ld           (bank_ld),
        .ld_data      (kern_res),
        .ld_row       (a_row_reg),
        .ld_col       (a_col_reg),
        .free         (bank_free),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .pix          (out_pix),
        .row          (out_row),
        .col          (out_col),
        .run_last     (run_last),
        .frame_last   (frame_last)
    );

    assign red_out   = out_pix[2*CB +: CB];
    assign green_out = out_pix[CB +: CB];
    assign blue_out  = out_pix[0 +: CB];

    assert property (@(posedge clk) disable iff (!rst_n)
        sec_pend_reg |-> !older_prim_we)
        else $error("older row buffer write port collision");

    assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && !pixel_stall) |=> a_valid_reg)
        else $error("accepted pixel lost before the window stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && frame_last) |-> run_last)
        else $error("frame end result not the last of its pixel");

endmodule

// File: verif/sharpen_cross_kernel_filter_check.sv
`timescale 1ns / 1ps
// Sharpened-pixel predictor and result comparison for the cross-kernel sharpening filter.
module sharpen_cross_kernel_filter_check import scf_pkg::*; #(
    parameter int MAX_WIDTH    = 1024,
    parameter int CHANNEL_BITS = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                         pixel_valid,
    input  logic                         pixel_stall,
    input  logic [CHANNEL_BITS-1:0]      red_in,
    input  logic [CHANNEL_BITS-1:0]      green_in,
    input  logic [CHANNEL_BITS-1:0]      blue_in,
    input  logic                         result_valid,
    input  logic                         result_stall,
    input  logic [CHANNEL_BITS-1:0]      red_out,
    input  logic [CHANNEL_BITS-1:0]      green_out,
    input  logic [CHANNEL_BITS-1:0]      blue_out,
    input  logic [ROW_BITS-1:0]          out_row,
    input  logic [$clog2(MAX_WIDTH)-1:0] out_col,
    input  logic                         run_last,
    input  logic                         frame_last,
    output int                           failures,
    output int                           outstanding
);

    localparam int COL_BITS     = $clog2(MAX_WIDTH);
    localparam int CHAN_MAX     = (1 << CHANNEL_BITS) - 1;
    localparam int REPORT_LIMIT = 10;

    typedef logic [CHANNEL_BITS-1:0] chan_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } rgb_t;

    typedef struct packed {
        chan_t               red;
        chan_t               green;
        chan_t               blue;
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic                run_last;
        logic                frame_last;
    } out_pixel_t;

    rgb_t       above_line     [MAX_WIDTH];
    rgb_t       two_above_line [MAX_WIDTH];
    rgb_t       cur_hist       [2];
    rgb_t       prev_hist      [2];
    int         row_pos;
    int         col_pos;
    int         width_reg;
    int         height_reg;
    int         fail_total;
    out_pixel_t sharpened_q [$];
    out_pixel_t got;
    out_pixel_t want;

    function automatic int span(int v, int hi);
        return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    function automatic chan_t sharpen_chan(chan_t ce, chan_t up, chan_t dn, chan_t lf,
                                           chan_t rt);
        int v;
        v = 5 * int'(ce) - (int'(up) + int'(dn) + int'(lf) + int'(rt));
        if (v < 0)
            return '0;
        if (v > CHAN_MAX)
            return chan_t'(CHAN_MAX);
        return chan_t'(v);
    endfunction

    function automatic out_pixel_t shade(rgb_t ce, rgb_t up, rgb_t dn, rgb_t lf, rgb_t rt,
                                         int row, int col, logic flast);
        out_pixel_t o;
        o.red        = sharpen_chan(ce.red, up.red, dn.red, lf.red, rt.red);
        o.green      = sharpen_chan(ce.green, up.green, dn.green, lf.green, rt.green);
        o.blue       = sharpen_chan(ce.blue, up.blue, dn.blue, lf.blue, rt.blue);
        o.row        = ROW_BITS'(row);
        o.col        = COL_BITS'(col);
        o.run_last   = 1'b0;
        o.frame_last = flast;
        return o;
    endfunction

    function automatic string describe(out_pixel_t p);
        return $sformatf("rgb %02h %02h %02h row %0d col %0d run_last %0b frame_last %0b",
                         p.red, p.green, p.blue, p.row, p.col, p.run_last, p.frame_last);
    endfunction

    task automatic take_pixel(rgb_t x);
        int         w;
        int         h;
        int         c;
        int         r;
        int         n;
        int         i;
        logic       end_col;
        logic       last_row;
        rgb_t       p0;
        rgb_t       oc;
        rgb_t       o1;
        rgb_t       p1;
        rgb_t       p2;
        rgb_t       c1;
        rgb_t       c2;
        out_pixel_t burst [4];
        w        = span(width_reg, MAX_WIDTH);
        h        = span(height_reg, MAX_HEIGHT);
        c        = (col_pos > w - 1) ? w - 1 : col_pos;
        r        = (row_pos > h - 1) ? h - 1 : row_pos;
        end_col  = (c == w - 1);
        last_row = (r == h - 1);
        p0       = above_line[c];
        oc       = two_above_line[c];
        o1       = (c >= 1) ? two_above_line[c - 1] : oc;
        p1       = prev_hist[0];
        p2       = prev_hist[1];
        c1       = cur_hist[0];
        c2       = cur_hist[1];
        n        = 0;
        if (r >= 1 && c >= 1)
        begin
            burst[n] = shade(p1, (r == 1) ? p1 : o1, c1, (c >= 2) ? p2 : p1, p0,
                             r - 1, c - 1, 1'b0);
            n++;
        end
        if (r >= 1 && end_col)
        begin
            burst[n] = shade(p0, (r == 1) ? p0 : oc, x, (c >= 1) ? p1 : p0, p0,
                             r - 1, c, 1'b0);
            n++;
        end
        if (last_row && c >= 1)
        begin
            burst[n] = shade(c1, (r >= 1) ? p1 : c1, c1, (c >= 2) ? c2 : c1, x,
                             r, c - 1, 1'b0);
            n++;
        end
        if (last_row && end_col)
        begin
            burst[n] = shade(x, (r >= 1) ? p0 : x, x, (c >= 1) ? c1 : x, x, r, c, 1'b1);
            n++;
        end
        if (n > 0)
            burst[n - 1].run_last = 1'b1;
        for (i = 0; i < n; i++)
            sharpened_q.push_back(burst[i]);

        if (c >= 1)
            two_above_line[c - 1] = p1;
        if (end_col)
            two_above_line[c] = p0;
        above_line[c] = x;
        prev_hist[1]  = p1;
        prev_hist[0]  = p0;
        cur_hist[1]   = c1;
        cur_hist[0]   = x;
        if (end_col)
        begin
            col_pos = 0;
            row_pos = last_row ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
            row_pos = r;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_WIDTH; k++)
            begin
                above_line[k]     = '0;
                two_above_line[k] = '0;
            end
            cur_hist[0]  = '0;
            cur_hist[1]  = '0;
            prev_hist[0] = '0;
            prev_hist[1] = '0;
            row_pos      = 0;
            col_pos      = 0;
            width_reg    = FW_RESET;
            height_reg   = FH_RESET;
            fail_total   = 0;
            sharpened_q.delete();
            failures    <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_FRAME_WIDTH)
                    width_reg = int'(cfg_data[FW_BITS-1:0]);
                else if (cfg_index == REG_FRAME_HEIGHT)
                    height_reg = int'(cfg_data[FH_BITS-1:0]);
            end
            if (pixel_valid && !pixel_stall)
                take_pixel({red_in, green_in, blue_in});
            if (result_valid && !result_stall)
            begin
                got = {red_out, green_out, blue_out, out_row, out_col, run_last, frame_last};
                if (sharpened_q.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= REPORT_LIMIT)
                        $display("unexpected transaction: %s", describe(got));
                end
                else
                begin
                    want = sharpened_q.pop_front();
                    if (got !== want)
                    begin
                        fail_total++;
                        if (fail_total <= REPORT_LIMIT)
                            $display("mismatch: expected %s, got %s",
                                     describe(want), describe(got));
                    end
                end
            end
            failures    <= fail_total;
            outstanding <= sharpened_q.size();
        end
    end

endmodule

// File: verif/sharpen_cross_kernel_filter_test.sv
`timescale 1ns / 1ps
// Stimulus, handshake pacing and verdict for the cross-kernel sharpening filter.
module sharpen_cross_kernel_filter_test;
    import scf_pkg::*;

    localparam int MAX_WIDTH       = 1024;
    localparam int CHANNEL_BITS    = 8;
    localparam int LATENCY_PAUSE   = 4;
    localparam int QUIET_LIMIT     = 1000;
    localparam int RANDOM_PER_MODE = 85;
    localparam int HOLD_CYCLES     = 80;
    localparam int WIDE_PIXELS     = 40;
    localparam int TALL_PIXELS     = 24;

    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = 2'd3;

    typedef logic [CHANNEL_BITS-1:0] chan_t;

    logic                         clk          = 1'b0;
    logic                         rst_n        = 1'b0;
    logic                         cfg_valid    = 1'b0;
    logic                         cfg_ready;
    logic [CFG_IDX_BITS-1:0]      cfg_index    = REG_FRAME_WIDTH;
    logic [CFG_DATA_BITS-1:0]     cfg_data     = '0;
    logic                         pixel_valid  = 1'b0;
    logic                         pixel_stall;
    chan_t                        red_in       = '0;
    chan_t                        green_in     = '0;
    chan_t                        blue_in      = '0;
    logic                         result_valid;
    logic                         result_stall = 1'b0;
    chan_t                        red_out;
    chan_t                        green_out;
    chan_t                        blue_out;
    logic [ROW_BITS-1:0]          out_row;
    logic [$clog2(MAX_WIDTH)-1:0] out_col;
    logic                         run_last;
    logic                         frame_last;
    int                           failures;
    int                           outstanding;

    int idle_pct    = 0;
    int stall_pct   = 0;
    int hold_left   = 0;
    int quiet       = 0;
    int pixels_sent = 0;
    int width_set   = FW_RESET;
    int height_set  = FH_RESET;
    int col_at      = 0;
    int row_at      = 0;

    sharpen_cross_kernel_filter #(
        .MAX_WIDTH    (MAX_WIDTH),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) dut (.*);

    sharpen_cross_kernel_filter_check #(
        .MAX_WIDTH    (MAX_WIDTH),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) sharpen_check (.*);

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            result_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("FAIL sharpen_cross_kernel_filter");
            $finish;
        end
    end

    function automatic int span(int v, int hi);
        return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    function automatic chan_t level();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return chan_t'($urandom);
        endcase
    endfunction

    task automatic settle();
        pixel_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (LATENCY_PAUSE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_FRAME_WIDTH)
            width_set = int'(data[FW_BITS-1:0]);
        else if (idx == REG_FRAME_HEIGHT)
            height_set = int'(data[FH_BITS-1:0]);
    endtask

    task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b);
        int w;
        int h;
        int c;
        int rr;
        while ($urandom_range(99) < idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        red_in      <= r;
        green_in    <= g;
        blue_in     <= b;
        do @(posedge clk); while (pixel_stall);
        pixels_sent++;
        // advance the raster position the way the block does
        w  = span(width_set, MAX_WIDTH);
        h  = span(height_set, MAX_HEIGHT);
        c  = (col_at > w - 1) ? w - 1 : col_at;
        rr = (row_at > h - 1) ? h - 1 : row_at;
        if (c == w - 1)
        begin
            col_at = 0;
            row_at = (rr == h - 1) ? 0 : rr + 1;
        end
        else
        begin
            col_at = c + 1;
            row_at = rr;
        end
    endtask

    task automatic finish_frame();
        while (col_at != 0 || row_at != 0)
            send_pixel(level(), level(), level());
    endtask

    initial
    begin
        int w;
        int h;
        int first;
        int mode;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // small frame with extreme neighborhoods
        write_reg(REG_FRAME_WIDTH, 13'd3);
        write_reg(REG_FRAME_HEIGHT, 13'd3);
        for (int i = 0; i < 9; i++)
            send_pixel((i % 2 == 0) ? 8'd255 : 8'd0, (i % 3 == 0) ? 8'd0 : 8'd255,
                       (i == 4) ? 8'd255 : chan_t'(i * 30));

        // zero size means one pixel per frame
        write_reg(REG_FRAME_WIDTH, 13'd0);
        write_reg(REG_FRAME_HEIGHT, 13'd0);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd1, 8'd128, 8'd254);

        // unused indexes and width bits above the register
        write_reg(REG_SPARE_A, 13'h1FFF);
        write_reg(REG_SPARE_B, 13'h1FFF);
        write_reg(REG_FRAME_WIDTH, 13'h1803);
        write_reg(REG_FRAME_HEIGHT, 13'd2);
        repeat (6) send_pixel(level(), level(), level());

        // oversized width, then shrink past the column counter
        write_reg(REG_FRAME_WIDTH, 13'd2047);
        write_reg(REG_FRAME_HEIGHT, 13'd1);
        repeat (5) send_pixel(level(), level(), level());
        write_reg(REG_FRAME_WIDTH, 13'd5);
        finish_frame();

        // widest rows, oversized height, then shrink both mid-frame
        write_reg(REG_FRAME_WIDTH, 13'd1024);
        write_reg(REG_FRAME_HEIGHT, 13'd8191);
        repeat (WIDE_PIXELS) send_pixel(level(), level(), level());
        write_reg(REG_FRAME_WIDTH, 13'd2);
        send_pixel(level(), level(), level());
        write_reg(REG_FRAME_HEIGHT, 13'd2);
        finish_frame();

        // tallest frame, one column, cut short past the row counter
        write_reg(REG_FRAME_WIDTH, 13'd1);
        write_reg(REG_FRAME_HEIGHT, 13'd4096);
        repeat (TALL_PIXELS) send_pixel(level(), level(), level());
        write_reg(REG_FRAME_HEIGHT, 13'd3);
        finish_frame();

        for (mode = 0; mode < 4; mode++)
        begin
            case (mode)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 54; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 54; end
                default: begin idle_pct = 30; stall_pct = 30; end
            endcase
            first = pixels_sent;
            while (pixels_sent - first < RANDOM_PER_MODE)
            begin
                w = ($urandom_range(4) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
                h = $urandom_range(5, 1);
                if (mode == 0 && pixels_sent == first)
                begin
                    w = 12;
                    h = 3;
                end
                write_reg(REG_FRAME_WIDTH, CFG_DATA_BITS'(w));
                write_reg(REG_FRAME_HEIGHT, CFG_DATA_BITS'(h));
                // hold the output while pixels keep coming
                if (mode == 0 && pixels_sent == first)
                    hold_left = HOLD_CYCLES;
                if ($urandom_range(5) == 0)
                    write_reg(REG_SPARE_A, CFG_DATA_BITS'($urandom));
                if (w * h > 1 && $urandom_range(2) == 0)
                begin
                    repeat ($urandom_range(w * h - 1, 1))
                        send_pixel(level(), level(), level());
                    if ($urandom_range(1) == 0)
                        write_reg(REG_FRAME_WIDTH, CFG_DATA_BITS'($urandom_range(w, 0)));
                    else
                        write_reg(REG_FRAME_HEIGHT, CFG_DATA_BITS'($urandom_range(h, 0)));
                end
                finish_frame();
            end
        end

        settle();
        if (failures == 0 && outstanding == 0)
            $display("PASS sharpen_cross_kernel_filter");
        else
            $display("FAIL sharpen_cross_kernel_filter");
        $finish;
    end

endmodule
